@@ rtl/mdec_pkg.sv @@
// ----------------------------------------------------------------------------
// mdec_pkg
// Shared types and codes for the instruction decoder: opcodes, function
// codes, instruction identities, format classes and the decoded result.
// ----------------------------------------------------------------------------
package mdec_pkg;

   // Instruction word layout.
   localparam int unsigned WORD_W   = 32;
   localparam int unsigned OP_W     = 6;
   localparam int unsigned REG_W    = 5;
   localparam int unsigned IMM_W    = 16;
   localparam int unsigned TARGET_W = 26;
   localparam int unsigned OP_LSB   = 26;

   // Primary opcodes.
   typedef enum logic [OP_W-1:0] {
      OP_SPECIAL = 6'd0,
      OP_J       = 6'd2,
      OP_JAL     = 6'd3,
      OP_BEQ     = 6'd4,
      OP_BNE     = 6'd5,
      OP_BGTZ    = 6'd7,
      OP_ADDI    = 6'd8,
      OP_ADDIU   = 6'd9,
      OP_SLTI    = 6'd10,
      OP_ANDI    = 6'd12,
      OP_ORI     = 6'd13,
      OP_NORI    = 6'd14,
      OP_LUI     = 6'd15,
      OP_LB      = 6'd32,
      OP_LH      = 6'd33,
      OP_LW      = 6'd35,
      OP_LBU     = 6'd36,
      OP_LHU     = 6'd37,
      OP_SB      = 6'd40,
      OP_SH      = 6'd41,
      OP_SW      = 6'd43,
      OP_HALT    = 6'd63
   } opcode_type;

   // Function codes under the special opcode.
   typedef enum logic [OP_W-1:0] {
      FN_SLL  = 6'd0,
      FN_SRL  = 6'd2,
      FN_SRA  = 6'd3,
      FN_JR   = 6'd8,
      FN_ADD  = 6'd32,
      FN_ADDU = 6'd33,
      FN_SUB  = 6'd34,
      FN_AND  = 6'd36,
      FN_OR   = 6'd37,
      FN_XOR  = 6'd38,
      FN_NOR  = 6'd39,
      FN_NAND = 6'd40,
      FN_SLT  = 6'd42
   } funct_type;

   // Instruction identities.
   typedef enum logic [5:0] {
      ID_ADD   = 6'd0,
      ID_ADDU  = 6'd1,
      ID_SUB   = 6'd2,
      ID_AND   = 6'd3,
      ID_OR    = 6'd4,
      ID_XOR   = 6'd5,
      ID_NOR   = 6'd6,
      ID_NAND  = 6'd7,
      ID_SLT   = 6'd8,
      ID_SLL   = 6'd9,
      ID_SRL   = 6'd10,
      ID_SRA   = 6'd11,
      ID_JR    = 6'd12,
      ID_ADDI  = 6'd13,
      ID_ADDIU = 6'd14,
      ID_LW    = 6'd15,
      ID_LH    = 6'd16,
      ID_LHU   = 6'd17,
      ID_LB    = 6'd18,
      ID_LBU   = 6'd19,
      ID_SW    = 6'd20,
      ID_SH    = 6'd21,
      ID_SB    = 6'd22,
      ID_LUI   = 6'd23,
      ID_ANDI  = 6'd24,
      ID_ORI   = 6'd25,
      ID_NORI  = 6'd26,
      ID_SLTI  = 6'd27,
      ID_BEQ   = 6'd28,
      ID_BNE   = 6'd29,
      ID_BGTZ  = 6'd30,
      ID_J     = 6'd31,
      ID_JAL   = 6'd32,
      ID_HALT  = 6'd33
   } inst_id_type;

   // Format classes.
   typedef enum logic [2:0] {
      FMT_R     = 3'd0,
      FMT_SHIFT = 3'd1,
      FMT_JR    = 3'd2,
      FMT_I     = 3'd3,
      FMT_LUI   = 3'd4,
      FMT_BGTZ  = 3'd5,
      FMT_J     = 3'd6,
      FMT_HALT  = 3'd7
   } format_type;

   // One decoded instruction.
   typedef struct packed {
      inst_id_type           inst_id;
      logic                  known;
      format_type            format_class;
      logic [REG_W-1:0]      src_reg;
      logic [REG_W-1:0]      tgt_reg;
      logic [REG_W-1:0]      dst_reg;
      logic [REG_W-1:0]      shift_amount;
      logic [WORD_W-1:0]     imm_value;
      logic [TARGET_W-1:0]   jump_target;
      logic                  halt;
   } decode_type;

endpackage

@@ rtl/mdec_req_if.sv @@
// ----------------------------------------------------------------------------
// mdec_req_if
// Instruction channel: one raw instruction word per transfer.
// ----------------------------------------------------------------------------
interface mdec_req_if
   import mdec_pkg::*;
   ();

   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] instr_word;

   modport source (output valid, output instr_word, input ready);
   modport sink   (input valid, input instr_word, output ready);

endinterface

@@ rtl/mdec_rsp_if.sv @@
// ----------------------------------------------------------------------------
// mdec_rsp_if
// Result channel: one decoded instruction per transfer.
// ----------------------------------------------------------------------------
interface mdec_rsp_if
   import mdec_pkg::*;
   ();

   logic                valid;
   logic                ready;
   logic [5:0]          inst_id;
   logic                known;
   logic [2:0]          format_class;
   logic [REG_W-1:0]    src_reg;
   logic [REG_W-1:0]    tgt_reg;
   logic [REG_W-1:0]    dst_reg;
   logic [REG_W-1:0]    shift_amount;
   logic [WORD_W-1:0]   imm_value;
   logic [TARGET_W-1:0] jump_target;
   logic                halt;

   modport source (
      output valid, output inst_id, output known, output format_class,
      output src_reg, output tgt_reg, output dst_reg, output shift_amount,
      output imm_value, output jump_target, output halt, input ready
   );
   modport sink (
      input valid, input inst_id, input known, input format_class,
      input src_reg, input tgt_reg, input dst_reg, input shift_amount,
      input imm_value, input jump_target, input halt, output ready
   );

endinterface

@@ rtl/mips_subset_instruction_decoder_top.sv @@
// ----------------------------------------------------------------------------
// mips_subset_instruction_decoder_top
// Instruction decoder for a MIPS-like subset with registered input and
// registered result.
// ----------------------------------------------------------------------------
// The decoder takes one instruction per cycle while the result port keeps
// up, and returns one result per instruction, in order. The word is captured
// in the input register, the decode logic feeds the result register whenever
// that register is free, and the result is offered on the result port from
// the result register. Throughput is one instruction per clock while the result
// port accepts, set by the combinational decode that lies between the two
// register stages of the pipeline; each register stage moves
// on whenever the stage after it is empty or is being emptied, so a stalled
// result port holds at most two instructions inside the block before the
// instruction port deasserts ready. Unlisted opcodes or function codes give
// known low with identity and format class zero; register, shift, immediate
// and target fields are always taken from the word. The block keeps no state
// beyond its pipeline.
// ----------------------------------------------------------------------------
module mips_subset_instruction_decoder_top
   import mdec_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   mdec_req_if.sink      req_in,
   mdec_rsp_if.source    rsp_out
);

   logic              in_valid_ff;
   logic              in_valid_in;
   logic [WORD_W-1:0] in_word_ff;
   logic              out_valid_ff;
   logic              out_valid_in;
   decode_type        out_result_ff;
   decode_type        decoded;
   logic              out_free;
   logic              in_free;

   // A stage can take a new entry when it is empty or its entry leaves now.
   assign out_free     = !out_valid_ff || rsp_out.ready;
   assign in_free      = !in_valid_ff || out_free;
   assign req_in.ready = in_free;

   assign in_valid_in  = req_in.valid || (in_valid_ff && !out_free);
   assign out_valid_in = in_valid_ff || (out_valid_ff && !rsp_out.ready);

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_free) begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_free && req_in.valid) begin
         in_word_ff <= req_in.instr_word;
      end
   end

   // Decode logic between the two registers.
   mdec_decode u_decode (
      .instr_word (in_word_ff),
      .decoded    (decoded)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && in_valid_ff) begin
         out_result_ff <= decoded;
      end
   end

   // Result port.
   assign rsp_out.valid        = out_valid_ff;
   assign rsp_out.inst_id      = out_result_ff.inst_id;
   assign rsp_out.known        = out_result_ff.known;
   assign rsp_out.format_class = out_result_ff.format_class;
   assign rsp_out.src_reg      = out_result_ff.src_reg;
   assign rsp_out.tgt_reg      = out_result_ff.tgt_reg;
   assign rsp_out.dst_reg      = out_result_ff.dst_reg;
   assign rsp_out.shift_amount = out_result_ff.shift_amount;
   assign rsp_out.imm_value    = out_result_ff.imm_value;
   assign rsp_out.jump_target  = out_result_ff.jump_target;
   assign rsp_out.halt         = out_result_ff.halt;

endmodule

@@ rtl/mdec_decode.sv @@
// ----------------------------------------------------------------------------
// mdec_decode
// Combinational decode of one instruction word into identity, format class
// and extracted fields.
// ----------------------------------------------------------------------------
module mdec_decode
   import mdec_pkg::*;
(
   input  logic [WORD_W-1:0] instr_word,
   output decode_type        decoded
);

   opcode_type        opcode;
   funct_type         funct;
   logic [IMM_W-1:0]  imm_raw;
   logic              zero_ext;

   assign opcode  = opcode_type'(instr_word[WORD_W-1:OP_LSB]);
   assign funct   = funct_type'(instr_word[OP_W-1:0]);
   assign imm_raw = instr_word[IMM_W-1:0];

   // The logical immediates are zero-extended; everything else, lui too,
   // is sign-extended.
   assign zero_ext = (opcode == OP_ANDI) || (opcode == OP_ORI) || (opcode == OP_NORI);

   always_comb begin
      decoded              = '0;
      decoded.src_reg      = instr_word[25:21];
      decoded.tgt_reg      = instr_word[20:16];
      decoded.dst_reg      = instr_word[15:11];
      decoded.shift_amount = instr_word[10:6];
      decoded.imm_value    = {{(WORD_W-IMM_W){imm_raw[IMM_W-1] & ~zero_ext}}, imm_raw};
      decoded.jump_target  = instr_word[TARGET_W-1:0];
      decoded.halt         = (opcode == OP_HALT);
      decoded.inst_id      = ID_ADD;
      decoded.format_class = FMT_R;
      decoded.known        = 1'b1;

      // Identity and format class; unlisted codes clear known.
      unique case (opcode)
         OP_SPECIAL: begin
            unique case (funct)
               FN_ADD:  decoded.inst_id = ID_ADD;
               FN_ADDU: decoded.inst_id = ID_ADDU;
               FN_SUB:  decoded.inst_id = ID_SUB;
               FN_AND:  decoded.inst_id = ID_AND;
               FN_OR:   decoded.inst_id = ID_OR;
               FN_XOR:  decoded.inst_id = ID_XOR;
               FN_NOR:  decoded.inst_id = ID_NOR;
               FN_NAND: decoded.inst_id = ID_NAND;
               FN_SLT:  decoded.inst_id = ID_SLT;
               FN_SLL: begin
                  decoded.inst_id      = ID_SLL;
                  decoded.format_class = FMT_SHIFT;
               end
               FN_SRL: begin
                  decoded.inst_id      = ID_SRL;
                  decoded.format_class = FMT_SHIFT;
               end
               FN_SRA: begin
                  decoded.inst_id      = ID_SRA;
                  decoded.format_class = FMT_SHIFT;
               end
               FN_JR: begin
                  decoded.inst_id      = ID_JR;
                  decoded.format_class = FMT_JR;
               end
               default: decoded.known = 1'b0;
            endcase
         end
         OP_ADDI:  begin decoded.inst_id = ID_ADDI;  decoded.format_class = FMT_I; end
         OP_ADDIU: begin decoded.inst_id = ID_ADDIU; decoded.format_class = FMT_I; end
         OP_LW:    begin decoded.inst_id = ID_LW;    decoded.format_class = FMT_I; end
         OP_LH:    begin decoded.inst_id = ID_LH;    decoded.format_class = FMT_I; end
         OP_LHU:   begin decoded.inst_id = ID_LHU;   decoded.format_class = FMT_I; end
         OP_LB:    begin decoded.inst_id = ID_LB;    decoded.format_class = FMT_I; end
         OP_LBU:   begin decoded.inst_id = ID_LBU;   decoded.format_class = FMT_I; end
         OP_SW:    begin decoded.inst_id = ID_SW;    decoded.format_class = FMT_I; end
         OP_SH:    begin decoded.inst_id = ID_SH;    decoded.format_class = FMT_I; end
         OP_SB:    begin decoded.inst_id = ID_SB;    decoded.format_class = FMT_I; end
         OP_LUI:   begin decoded.inst_id = ID_LUI;   decoded.format_class = FMT_LUI; end
         OP_ANDI:  begin decoded.inst_id = ID_ANDI;  decoded.format_class = FMT_I; end
         OP_ORI:   begin decoded.inst_id = ID_ORI;   decoded.format_class = FMT_I; end
         OP_NORI:  begin decoded.inst_id = ID_NORI;  decoded.format_class = FMT_I; end
         OP_SLTI:  begin decoded.inst_id = ID_SLTI;  decoded.format_class = FMT_I; end
         OP_BEQ:   begin decoded.inst_id = ID_BEQ;   decoded.format_class = FMT_I; end
         OP_BNE:   begin decoded.inst_id = ID_BNE;   decoded.format_class = FMT_I; end
         OP_BGTZ:  begin decoded.inst_id = ID_BGTZ;  decoded.format_class = FMT_BGTZ; end
         OP_J:     begin decoded.inst_id = ID_J;     decoded.format_class = FMT_J; end
         OP_JAL:   begin decoded.inst_id = ID_JAL;   decoded.format_class = FMT_J; end
         OP_HALT:  begin decoded.inst_id = ID_HALT;  decoded.format_class = FMT_HALT; end
         default:  decoded.known = 1'b0;
      endcase
   end

endmodule
